/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion shorthands; the user scope provides clk_i
// and rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// The antecedent at one edge implies the consequent at the next edge.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/sag_pkg.sv */
// ----------------------------------------------------------------------------
// Sliding attack generator package
// Ray geometry, command codes and the packets between pipeline stages.
// ----------------------------------------------------------------------------
`default_nettype none

package sag_pkg;

  localparam int unsigned NUM_RAYS      = 8;
  localparam int unsigned NUM_DIAG_RAYS = 4;
  localparam int unsigned RAY_LEN       = 7;
  localparam int unsigned SQ_W          = 6;
  localparam int unsigned BOARD_W       = 64;

  typedef enum logic [1:0] {
    CMD_DIAG  = 2'd0,
    CMD_ORTHO = 2'd1,
    CMD_BOTH  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  // Rank and file steps; rays 0..3 are diagonal, 4..7 orthogonal.
  localparam logic signed [1:0] RAY_DR [NUM_RAYS] =
    '{2'sd1, 2'sd1, -2'sd1, -2'sd1, 2'sd1, -2'sd1, 2'sd0, 2'sd0};
  localparam logic signed [1:0] RAY_DF [NUM_RAYS] =
    '{2'sd1, -2'sd1, 2'sd1, -2'sd1, 2'sd0, 2'sd0, 2'sd1, -2'sd1};

  typedef struct packed {
    logic            ok;
    logic [SQ_W-1:0] idx;
  } ray_tgt_t;

  typedef struct packed {
    cmd_e                                cmd;
    logic [SQ_W-1:0]                     sq;
    logic [NUM_RAYS-1:0][RAY_LEN-1:0]    occ;
    logic [NUM_RAYS-1:0][RAY_LEN-1:0]    ok;
  } gth_pkt_t;

  typedef struct packed {
    cmd_e                                cmd;
    logic [SQ_W-1:0]                     sq;
    logic [NUM_RAYS-1:0][RAY_LEN-1:0]    reach;
  } trc_pkt_t;

  function automatic logic signed [4:0] step_off(input logic signed [4:0] base,
                                                 input logic signed [1:0] dir,
                                                 input logic signed [4:0] n_steps);
    logic signed [4:0] res;
    res = base;
    if (dir == 2'sd1) begin
      res = base + n_steps;
    end else if (dir == -2'sd1) begin
      res = base - n_steps;
    end
    return res;
  endfunction

  // Square reached by walking n_steps steps from sq along ray, and whether it
  // is still on the board.
  function automatic ray_tgt_t ray_target(input logic [SQ_W-1:0] sq,
                                          input logic [2:0]      ray,
                                          input logic [2:0]      n_steps);
    logic signed [4:0] r;
    logic signed [4:0] f;
    logic signed [4:0] ds;
    ray_tgt_t          t;
    ds    = $signed({2'b00, n_steps});
    r     = step_off($signed({2'b00, sq[5:3]}), RAY_DR[ray], ds);
    f     = step_off($signed({2'b00, sq[2:0]}), RAY_DF[ray], ds);
    // Range is -7..14, so on-board means both upper bits are zero.
    t.ok  = (r[4:3] == 2'b00) && (f[4:3] == 2'b00);
    t.idx = {r[2:0], f[2:0]};
    return t;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/sag_gather.sv */
// ----------------------------------------------------------------------------
// Sliding attack generator, gather stage
// Picks the occupancy bits along each of the eight rays into short vectors.
// ----------------------------------------------------------------------------
`default_nettype none

module sag_gather import sag_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                valid_i,
  output logic                     ready_o,
  input  wire cmd_e                cmd_i,
  input  wire logic [SQ_W-1:0]     sq_i,
  input  wire logic [BOARD_W-1:0]  occ_i,
  output logic                     valid_o,
  input  wire logic                ready_i,
  output gth_pkt_t                 pkt_o
);

  logic     vld_q;
  gth_pkt_t pkt_d;
  gth_pkt_t pkt_q;

  assign ready_o = !vld_q || ready_i;
  assign valid_o = vld_q;
  assign pkt_o   = pkt_q;

  always_comb begin : gather_blk
    ray_tgt_t t;
    pkt_d     = '0;
    pkt_d.cmd = cmd_i;
    pkt_d.sq  = sq_i;
    for (int k = 0; k < NUM_RAYS; k++) begin
      for (int s = 0; s < RAY_LEN; s++) begin
        t               = ray_target(sq_i, 3'(k), 3'(s + 1));
        pkt_d.ok[k][s]  = t.ok;
        pkt_d.occ[k][s] = occ_i[t.idx];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      pkt_q <= pkt_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/sag_trace.sv */
// ----------------------------------------------------------------------------
// Sliding attack generator, trace stage
// Walks each ray vector and marks squares up to and including the first
// blocker.
// ----------------------------------------------------------------------------
`default_nettype none

module sag_trace import sag_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      valid_i,
  output logic           ready_o,
  input  wire gth_pkt_t  pkt_i,
  output logic           valid_o,
  input  wire logic      ready_i,
  output trc_pkt_t       pkt_o
);

  logic     vld_q;
  trc_pkt_t pkt_d;
  trc_pkt_t pkt_q;

  assign ready_o = !vld_q || ready_i;
  assign valid_o = vld_q;
  assign pkt_o   = pkt_q;

  always_comb begin : trace_blk
    logic blocked;
    pkt_d     = '0;
    pkt_d.cmd = pkt_i.cmd;
    pkt_d.sq  = pkt_i.sq;
    for (int k = 0; k < NUM_RAYS; k++) begin
      blocked = 1'b0;
      for (int s = 0; s < RAY_LEN; s++) begin
        pkt_d.reach[k][s] = pkt_i.ok[k][s] && !blocked;
        blocked           = blocked || pkt_i.occ[k][s];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      pkt_q <= pkt_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/sag_scatter.sv */
// ----------------------------------------------------------------------------
// Sliding attack generator, scatter stage
// Places the reached ray squares back on the board, selects the ray groups
// by piece kind and holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sag_scatter import sag_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         valid_i,
  output logic              ready_o,
  input  wire trc_pkt_t     pkt_i,
  output logic              valid_o,
  input  wire logic         ready_i,
  output logic [BOARD_W-1:0] attacks_o
);

  logic               vld_q;
  logic [BOARD_W-1:0] att_d;
  logic [BOARD_W-1:0] att_q;

  assign ready_o   = !vld_q || ready_i;
  assign valid_o   = vld_q;
  assign attacks_o = att_q;

  always_comb begin : scatter_blk
    ray_tgt_t t;
    logic     use_diag;
    logic     use_ortho;
    logic     use_ray;
    use_diag  = (pkt_i.cmd == CMD_DIAG) || (pkt_i.cmd == CMD_BOTH);
    use_ortho = (pkt_i.cmd == CMD_ORTHO) || (pkt_i.cmd == CMD_BOTH);
    att_d     = '0;
    for (int k = 0; k < NUM_RAYS; k++) begin
      use_ray = (k < NUM_DIAG_RAYS) ? use_diag : use_ortho;
      for (int s = 0; s < RAY_LEN; s++) begin
        t = ray_target(pkt_i.sq, 3'(k), 3'(s + 1));
        if (use_ray && pkt_i.reach[k][s]) begin
          att_d[t.idx] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      att_q <= att_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/sliding_attack_generator.sv */
// ----------------------------------------------------------------------------
// Sliding attack generator
// Attack set of a bishop, rook or queen on an 8x8 bitboard.
// ----------------------------------------------------------------------------
// The block takes one item per clock while ready and returns its attack set
// through three register stages: gather picks the occupancy bits of
// the eight rays, trace finds the first blocker on each ray, and scatter
// builds the 64-bit board in the output register. A stalled output holds its
// item while the stages behind it fill; back-pressure reaches the input only
// once all three stages hold items. Squares are numbered rank times eight
// plus file, the origin square is never attacked, and the first occupied
// square on each ray is included. Piece kind 3 returns an empty board.
`default_nettype none
`include "assert_macros.svh"

module sliding_attack_generator import sag_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [71:0] s_axis_tdata_i,   // [5:0] square, [69:6] occupancy
  input  wire logic [1:0]  s_axis_tuser_i,   // [1:0] command
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [63:0]      m_axis_tdata_o    // [63:0] attacks
);

  logic     gth_vld;
  logic     gth_rdy;
  gth_pkt_t gth_pkt;
  logic     trc_vld;
  logic     trc_rdy;
  trc_pkt_t trc_pkt;

  sag_gather u_gather (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .cmd_i   (cmd_e'(s_axis_tuser_i)),
    .sq_i    (s_axis_tdata_i[5:0]),
    .occ_i   (s_axis_tdata_i[69:6]),
    .valid_o (gth_vld),
    .ready_i (gth_rdy),
    .pkt_o   (gth_pkt)
  );

  sag_trace u_trace (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (gth_vld),
    .ready_o (gth_rdy),
    .pkt_i   (gth_pkt),
    .valid_o (trc_vld),
    .ready_i (trc_rdy),
    .pkt_o   (trc_pkt)
  );

  sag_scatter u_scatter (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (trc_vld),
    .ready_o   (trc_rdy),
    .pkt_i     (trc_pkt),
    .valid_o   (m_axis_tvalid_o),
    .ready_i   (m_axis_tready_i),
    .attacks_o (m_axis_tdata_o)
  );

  // An empty first stage never holds off the input.
  `ASSERT_ALWAYS(a_entry_ready, !gth_vld -> s_axis_tready_o, "input stalled with empty stage")
  // An item leaving gather is held by trace on the next cycle.
  `ASSERT_NEXT(a_gth_to_trc, gth_vld && gth_rdy, trc_vld, "item lost after gather")
  // An item leaving trace shows up at the output on the next cycle.
  `ASSERT_NEXT(a_trc_to_out, trc_vld && trc_rdy, m_axis_tvalid_o, "item lost after trace")

endmodule

`default_nettype wire
